FILE: rtl/ipsc_pkg.sv
// Shared types and fixed widths for the incremental PI speed controller.
`timescale 1ns / 1ps
`default_nettype none
package ipsc_pkg;

	// Fixed field widths
	localparam int unsigned SPEED_W = 16;
	localparam int unsigned GAIN_W  = 20;
	localparam int unsigned DUTY_W  = 7;
	localparam int unsigned LEVEL_W = 24;
	localparam int unsigned ERR_W   = SPEED_W + 1;
	localparam int unsigned DERR_W  = ERR_W + 1;
	// Signed product of a zero-extended gain and the wider error term
	localparam int unsigned PROD_W  = GAIN_W + 1 + DERR_W;
	// Accumulator plus two products; fits accumulators up to PROD_W bits
	localparam int unsigned SUM_W   = PROD_W + 2;

	// Configuration port
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	typedef enum logic {
		REG_PROP_GAIN  = 1'b0,
		REG_INTEG_GAIN = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic [GAIN_W-1:0] prop_gain;
		logic [GAIN_W-1:0] integ_gain;
	} gains_t;

	// Control from the input stage to the update stage
	typedef struct packed {
		logic load;
		logic advance;
	} stage_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/ipsc_if.sv
// Valid/ready channel interfaces for speed samples and duty results.
`timescale 1ns / 1ps
`default_nettype none
interface ipsc_in_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [ipsc_pkg::SPEED_W-1:0]    target_speed;
	logic signed [ipsc_pkg::SPEED_W-1:0]    measured_speed;

	modport source (output valid, output target_speed, output measured_speed, input ready);
	modport sink (input valid, input target_speed, input measured_speed, output ready);
endinterface

interface ipsc_out_if;
	logic                                   valid;
	logic                                   ready;
	logic [ipsc_pkg::DUTY_W-1:0]            forward_duty;
	logic [ipsc_pkg::DUTY_W-1:0]            reverse_duty;
	logic signed [ipsc_pkg::LEVEL_W-1:0]    drive_level;

	modport source (output valid, output forward_duty, output reverse_duty,
		output drive_level, input ready);
	modport sink (input valid, input forward_duty, input reverse_duty,
		input drive_level, output ready);
endinterface
`default_nettype wire

FILE: rtl/ipsc_apb_regs.sv
// APB register file holding the proportional and integral gains.
`timescale 1ns / 1ps
`default_nettype none
module ipsc_apb_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [ipsc_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire logic [ipsc_pkg::APB_DATA_W-1:0]     pwdata,
	output      logic [ipsc_pkg::APB_DATA_W-1:0]     prdata,
	output      logic                                pready,
	output      ipsc_pkg::gains_t                    gains
);

	ipsc_pkg::gains_t   gains_q;
	ipsc_pkg::reg_index_t reg_sel;
	logic               wr_en;

	// Word select ignores the byte offset
	assign reg_sel = ipsc_pkg::reg_index_t'(paddr[2]);
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;

	// Write the selected gain on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q <= '0;
		end else if (wr_en) begin
			unique case (reg_sel)
				ipsc_pkg::REG_PROP_GAIN:  gains_q.prop_gain  <= pwdata[ipsc_pkg::GAIN_W-1:0];
				ipsc_pkg::REG_INTEG_GAIN: gains_q.integ_gain <= pwdata[ipsc_pkg::GAIN_W-1:0];
				default:                  gains_q <= gains_q;
			endcase
		end
	end

	// Read back the selected gain, zero-extended
	always_comb begin
		unique case (reg_sel)
			ipsc_pkg::REG_PROP_GAIN:  prdata = ipsc_pkg::APB_DATA_W'(gains_q.prop_gain);
			ipsc_pkg::REG_INTEG_GAIN: prdata = ipsc_pkg::APB_DATA_W'(gains_q.integ_gain);
			default:                  prdata = '0;
		endcase
	end

	assign gains = gains_q;

endmodule
`default_nettype wire

FILE: rtl/ipsc_update.sv
// Drive update: gains times error terms, accumulate, clamp, split into duties.
`timescale 1ns / 1ps
`default_nettype none
module ipsc_update #(
	parameter int unsigned DUTY_LIMIT = 70,
	parameter int unsigned FRAC_BITS  = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire ipsc_pkg::stage_ctrl_t                ctrl,
	input  wire ipsc_pkg::gains_t                     gains,
	input  wire logic signed [ipsc_pkg::ERR_W-1:0]    err_s1,
	ipsc_out_if.source                                rsp
);

	localparam int unsigned ACC_W = $clog2(DUTY_LIMIT + 1) + FRAC_BITS + 1;
	localparam int unsigned SUM_W = ipsc_pkg::SUM_W;
	localparam logic signed [SUM_W-1:0] LIMIT     = SUM_W'(DUTY_LIMIT) <<< FRAC_BITS;
	localparam logic signed [SUM_W-1:0] NEG_LIMIT = -LIMIT;

	logic signed [ACC_W-1:0]                  drive_accum_q;
	logic signed [ipsc_pkg::ERR_W-1:0]        prev_err_q;
	logic signed [ipsc_pkg::DERR_W-1:0]       derr;
	logic signed [ipsc_pkg::PROD_W-1:0]       prod_p;
	logic signed [ipsc_pkg::PROD_W-1:0]       prod_i;
	logic signed [SUM_W-1:0]                  sum;
	logic signed [SUM_W-1:0]                  clamped;
	logic signed [SUM_W-1:0]                  mag;
	logic signed [SUM_W-1:0]                  mag_int;
	logic                                     positive;
	logic                                     out_valid_q;
	logic [ipsc_pkg::DUTY_W-1:0]              fwd_q;
	logic [ipsc_pkg::DUTY_W-1:0]              rev_q;
	logic signed [ipsc_pkg::LEVEL_W-1:0]      level_q;

	// Error change and the two gain products
	always_comb begin
		derr   = ipsc_pkg::DERR_W'(err_s1) - ipsc_pkg::DERR_W'(prev_err_q);
		prod_p = $signed({1'b0, gains.prop_gain}) * derr;
		prod_i = $signed({1'b0, gains.integ_gain}) * ipsc_pkg::DERR_W'(err_s1);
	end

	// Accumulate and clamp for anti-windup
	always_comb begin
		sum = SUM_W'(drive_accum_q) + SUM_W'(prod_p) + SUM_W'(prod_i);
		priority if (sum > LIMIT) begin
			clamped = LIMIT;
		end else if (sum < NEG_LIMIT) begin
			clamped = NEG_LIMIT;
		end else begin
			clamped = sum;
		end
	end

	// Split into H-bridge duties; zero drive goes to the reverse side as zero
	always_comb begin
		positive = (clamped > 0);
		mag      = positive ? clamped : -clamped;
		mag_int  = mag >>> FRAC_BITS;
	end

	// Hold controller state, advance on each loaded sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_accum_q <= '0;
			prev_err_q    <= '0;
		end else if (ctrl.load) begin
			drive_accum_q <= clamped[ACC_W-1:0];
			prev_err_q    <= err_s1;
		end
	end

	// Result register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.advance) begin
			out_valid_q <= ctrl.load;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			fwd_q   <= positive ? mag_int[ipsc_pkg::DUTY_W-1:0] : '0;
			rev_q   <= positive ? '0 : mag_int[ipsc_pkg::DUTY_W-1:0];
			level_q <= clamped[ipsc_pkg::LEVEL_W-1:0];
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.forward_duty = fwd_q;
	assign rsp.reverse_duty = rev_q;
	assign rsp.drive_level  = level_q;

`ifndef NO_ASSERTIONS
	a_accum_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(SUM_W'(drive_accum_q) <= LIMIT) && (SUM_W'(drive_accum_q) >= NEG_LIMIT))
		else $error("drive accumulator outside duty limit");
	a_duty_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((fwd_q == '0) || (rev_q == '0)))
		else $error("forward and reverse duty both active");
	a_load_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load |=> out_valid_q)
		else $error("loaded sample produced no result");
`endif

endmodule
`default_nettype wire

FILE: rtl/incremental_pi_speed_ctrl_core.sv
// Top level of the incremental PI speed controller.
// Usage:
//   speed  : sink channel; each transfer carries one control tick
//            (target_speed and measured_speed, signed counts per tick).
//   duty   : source channel; one transfer per tick with forward_duty,
//            reverse_duty and the clamped drive_level (signed Q fraction).
//   APB    : prop_gain at byte address 0, integ_gain at 4; write only while
//            no tick is in flight. pready is always high.
// Path: a tick passes the sample register, then the result register.
// Throughput: one tick per cycle while duty is not stalled; the sample
// register feeds the multiply, accumulate and clamp path, which is
// combinational into the result register and the accumulator state.
// Stall: while duty is not taken the result register holds, and one more
// tick may be taken into the sample register before speed.ready drops.
// Reset: asynchronous, active low; clears both gains, the accumulator,
// the previous error and all valid flags.
`timescale 1ns / 1ps
`default_nettype none
module incremental_pi_speed_ctrl_core #(
	parameter int unsigned DUTY_LIMIT = 70,
	parameter int unsigned FRAC_BITS  = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	ipsc_in_if.sink                                  speed,
	ipsc_out_if.source                               duty,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [ipsc_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire logic [ipsc_pkg::APB_DATA_W-1:0]     pwdata,
	output      logic [ipsc_pkg::APB_DATA_W-1:0]     prdata,
	output      logic                                pready
);

	ipsc_pkg::gains_t                     gains;
	ipsc_pkg::stage_ctrl_t                ctrl;
	logic                                 valid_s1;
	logic signed [ipsc_pkg::ERR_W-1:0]    err_s1;
	logic                                 in_xfer;

	ipsc_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.gains   (gains)
	);

	// Stage handshake: result register frees when empty or taken
	always_comb begin
		ctrl.advance = ~duty.valid | duty.ready;
		ctrl.load    = valid_s1 & ctrl.advance;
		speed.ready  = ~valid_s1 | ctrl.advance;
		in_xfer      = speed.valid & speed.ready;
	end

	// Sample register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (speed.ready) begin
			valid_s1 <= speed.valid;
		end
	end

	// Form the error on the way in
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			err_s1 <= ipsc_pkg::ERR_W'(speed.target_speed) - ipsc_pkg::ERR_W'(speed.measured_speed);
		end
	end

	ipsc_update #(
		.DUTY_LIMIT (DUTY_LIMIT),
		.FRAC_BITS  (FRAC_BITS)
	) u_update (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.gains  (gains),
		.err_s1 (err_s1),
		.rsp    (duty)
	);

`ifndef NO_ASSERTIONS
	a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!speed.ready |-> (valid_s1 && duty.valid && !duty.ready))
		else $error("input stalled with room downstream");
	a_transfer_fills_stage: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> valid_s1)
		else $error("accepted sample lost from sample register");
	a_stalled_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !ctrl.advance) |=> (valid_s1 && $stable(err_s1)))
		else $error("stalled sample changed");
`endif

endmodule
`default_nettype wire
